// ===== hdl/idle_worker_task_dispatcher_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the idle worker task dispatcher
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef IDLE_WORKER_TASK_DISPATCHER_ASSERT_SVH
`define IDLE_WORKER_TASK_DISPATCHER_ASSERT_SVH

// same-cycle implication
`define IDWTD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("idwtd: same-cycle check failed");

// next-cycle implication
`define IDWTD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("idwtd: next-cycle check failed");

`endif

// ===== hdl/idwtd_pkg.sv =====
// ---------------------------------------------------------------------------
// idwtd_pkg
// Types, codes and defaults shared by the idle worker task dispatcher.
// ---------------------------------------------------------------------------
package idwtd_pkg;

	localparam int MAX_WORKERS_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF  = 16;
	localparam int TASK_ID_BITS_DEF = 32;

	localparam int WORKER_W = 4;
	localparam int ID_PORT_W = 32;
	localparam int HANDLE_W = 32;
	localparam int ACTIVE_W = 5;
	localparam int POLLER_W = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 5;
	// wide enough for every index and count compared in the block
	localparam int CMP_W = 8;

	localparam logic [POLLER_W-1:0] NO_POLLER    = 5'd16;
	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WORKERS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POLL_BY_IDLE   = 1'd1;

	typedef enum logic [1:0] {
		OP_SUBMIT  = 2'd0,
		OP_FINISH  = 2'd1,
		OP_CLAIM   = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STS_DISPATCHED = 3'd0,
		STS_QUEUED     = 3'd1,
		STS_DROPPED    = 3'd2,
		STS_IDLED      = 3'd3,
		STS_ACK        = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_READ,
		S_DONE
	} state_t;

	typedef struct packed {
		logic done;
		logic found;
	} scan_stat_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

endpackage

// ===== hdl/idwtd_ram.sv =====
// ---------------------------------------------------------------------------
// idwtd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module idwtd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/idwtd_fifo.sv =====
// ---------------------------------------------------------------------------
// idwtd_fifo
// Pending task queue: head pointer and fill count around one RAM.
// ---------------------------------------------------------------------------
module idwtd_fifo #(
	parameter int DEPTH = idwtd_pkg::QUEUE_DEPTH_DEF,
	parameter int DW    = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [DW-1:0]          wdata,
	input  logic                   rd_req,
	input  logic                   pop,
	output logic [DW-1:0]          rdata,
	output idwtd_pkg::fifo_stat_t  stat
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW:0]   tail_sum;
	logic [AW-1:0] tail;
	logic [AW:0]   head_inc;

	// head + count stays below twice the depth: one compare and subtract
	always_comb begin
		tail_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
		if (tail_sum >= (CW+1)'(DEPTH)) begin
			tail = AW'(tail_sum - (CW+1)'(DEPTH));
		end else begin
			tail = AW'(tail_sum);
		end
		head_inc = (AW+1)'(head_q) + (AW+1)'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (push) begin
			count_q <= count_q + CW'(1);
		end else if (pop) begin
			head_q  <= (head_inc == (AW+1)'(DEPTH)) ? '0 : AW'(head_inc);
			count_q <= count_q - CW'(1);
		end
	end

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CW'(DEPTH));

	idwtd_ram #(
		.WIDTH (DW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (push),
		.waddr (tail),
		.wdata (wdata),
		.re    (rd_req),
		.raddr (head_q),
		.rdata (rdata)
	);

endmodule

// ===== hdl/idwtd_scan.sv =====
// ---------------------------------------------------------------------------
// idwtd_scan
// Round-robin idle search: one worker examined per cycle by a shared
// increment-and-wrap unit, the poller held back as last resort.
// ---------------------------------------------------------------------------
module idwtd_scan #(
	parameter int MAX_WORKERS = idwtd_pkg::MAX_WORKERS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [$clog2(MAX_WORKERS+1)-1:0]      n,
	input  logic [((MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1)-1:0] start_idx,
	input  logic [MAX_WORKERS-1:0]                busy,
	input  logic [idwtd_pkg::POLLER_W-1:0]        poller,
	input  logic                                  poll_mode,
	output idwtd_pkg::scan_stat_t                 stat,
	output logic [((MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1)-1:0] idx,
	output logic [((MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1)-1:0] next_idx
);

	localparam int IW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int NW = $clog2(MAX_WORKERS + 1);
	localparam int CW = idwtd_pkg::CMP_W;

	logic          run_q;
	logic          done_q;
	logic          found_q;
	logic          seen_q;
	logic [IW-1:0] pos_q;
	logic [NW-1:0] k_q;
	logic [IW-1:0] seen_idx_q;
	logic [IW-1:0] seen_next_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] next_q;

	logic [CW-1:0] pos_inc;
	logic [IW-1:0] pos_next;
	logic          idle_here;
	logic          hit_poller;
	logic          take;
	logic          last;

	always_comb begin
		pos_inc    = CW'(pos_q) + CW'(1);
		pos_next   = (pos_inc == CW'(n)) ? '0 : IW'(pos_inc);
		idle_here  = !busy[pos_q];
		hit_poller = poll_mode && (CW'(pos_q) == CW'(poller));
		take       = idle_here && !hit_poller;
		last       = (CW'(k_q) + CW'(1)) == CW'(n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
			seen_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				seen_q <= 1'b0;
			end else if (run_q) begin
				if (take) begin
					run_q   <= 1'b0;
					done_q  <= 1'b1;
					found_q <= 1'b1;
				end else if (last) begin
					run_q   <= 1'b0;
					done_q  <= 1'b1;
					found_q <= seen_q || (idle_here && hit_poller);
				end else if (idle_here && hit_poller) begin
					seen_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			pos_q <= start_idx;
			k_q   <= '0;
		end else if (run_q) begin
			pos_q <= pos_next;
			k_q   <= k_q + NW'(1);
			if (idle_here && hit_poller) begin
				seen_idx_q  <= pos_q;
				seen_next_q <= pos_next;
			end
			if (take || (idle_here && hit_poller)) begin
				idx_q  <= pos_q;
				next_q <= pos_next;
			end else if (last) begin
				idx_q  <= seen_idx_q;
				next_q <= seen_next_q;
			end
		end
	end

	assign stat.done  = done_q;
	assign stat.found = found_q;
	assign idx        = idx_q;
	assign next_idx   = next_q;

endmodule

// ===== hdl/idle_worker_task_dispatcher.sv =====
// ---------------------------------------------------------------------------
// idle_worker_task_dispatcher
// Round-robin task dispatch to a worker pool with a queue of pending tasks.
// ---------------------------------------------------------------------------
// One item is handled at a time; in_ready is high only between items, while
// a finished result may still wait in the output register. Each item passes
// through S_EXEC and then S_DONE, which waits for a free output register
// before the return to S_IDLE. A submit runs the idle search in S_SCAN
// between the two, checking one busy bit per cycle; a finish that picks up
// a queued task passes through S_READ for the registered read of the queue
// RAM. The queue RAM is not cleared after reset: its fill count governs
// every read, so the block is ready straight out of reset.
module idle_worker_task_dispatcher #(
	parameter int QUEUE_DEPTH  = idwtd_pkg::QUEUE_DEPTH_DEF,
	parameter int TASK_ID_BITS = idwtd_pkg::TASK_ID_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [idwtd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [idwtd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           operation,
	input  logic [idwtd_pkg::WORKER_W-1:0]       worker,
	input  logic [idwtd_pkg::ID_PORT_W-1:0]      task_id,
	input  logic [idwtd_pkg::HANDLE_W-1:0]       task_handle,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [2:0]                           status,
	output logic [idwtd_pkg::WORKER_W-1:0]       target_worker,
	output logic [idwtd_pkg::ID_PORT_W-1:0]      out_task_id,
	output logic [idwtd_pkg::HANDLE_W-1:0]       out_task_handle
);

	// pool size is bounded by the four-bit worker ports and the poller code
	localparam int MAX_WORKERS = idwtd_pkg::MAX_WORKERS_DEF;
	localparam int IW   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int NW   = $clog2(MAX_WORKERS + 1);
	localparam int CW   = idwtd_pkg::CMP_W;
	localparam int ID_W = (TASK_ID_BITS < idwtd_pkg::ID_PORT_W) ?
		TASK_ID_BITS : idwtd_pkg::ID_PORT_W;
	localparam int HW   = idwtd_pkg::HANDLE_W;
	localparam int DW   = ID_W + HW;

	idwtd_pkg::state_t state_q, state_d;

	// configuration
	logic [idwtd_pkg::ACTIVE_W-1:0] active_q;
	logic                           poll_mode_q;

	// dispatcher state
	logic [MAX_WORKERS-1:0]         busy_q;
	logic [IW-1:0]                  search_q;
	logic [idwtd_pkg::POLLER_W-1:0] poller_q;

	// item being worked on
	idwtd_pkg::op_t                 op_q;
	logic [idwtd_pkg::WORKER_W-1:0] wrk_q;
	logic [ID_W-1:0]                tid_q;
	logic [HW-1:0]                  th_q;

	// result waiting for the output register
	idwtd_pkg::status_t             res_status_q;
	logic [idwtd_pkg::WORKER_W-1:0] res_target_q;
	logic [ID_W-1:0]                res_id_q;
	logic [HW-1:0]                  res_th_q;

	// output register
	logic                           out_valid_q;
	idwtd_pkg::status_t             out_status_q;
	logic [idwtd_pkg::WORKER_W-1:0] out_target_q;
	logic [ID_W-1:0]                out_id_q;
	logic [HW-1:0]                  out_th_q;

	logic [NW-1:0]         n_w;
	logic [IW-1:0]         start_idx;
	logic [IW-1:0]         wrk_idx;
	logic                  w_ok;
	logic                  out_free;

	idwtd_pkg::scan_stat_t scan_stat;
	logic [IW-1:0]         scan_idx;
	logic [IW-1:0]         scan_next;
	idwtd_pkg::fifo_stat_t fifo_stat;
	logic [DW-1:0]         fifo_rdata;

	logic scan_start;
	logic fifo_rd;
	logic fifo_pop;
	logic fifo_push;
	logic load_out;

	// worker count clamped to 1 .. MAX_WORKERS
	always_comb begin
		if (active_q == '0) begin
			n_w = NW'(1);
		end else if (CW'(active_q) > CW'(MAX_WORKERS)) begin
			n_w = NW'(MAX_WORKERS);
		end else begin
			n_w = NW'(active_q);
		end
		start_idx = (CW'(search_q) < CW'(n_w)) ? search_q : '0;
		wrk_idx   = IW'(wrk_q);
		w_ok      = CW'(wrk_q) < CW'(n_w);
		out_free  = !out_valid_q || out_ready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			idwtd_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = idwtd_pkg::S_EXEC;
				end
			end
			idwtd_pkg::S_EXEC: begin
				case (op_q)
					idwtd_pkg::OP_SUBMIT: state_d = idwtd_pkg::S_SCAN;
					idwtd_pkg::OP_FINISH: begin
						state_d = (w_ok && !fifo_stat.empty) ?
							idwtd_pkg::S_READ : idwtd_pkg::S_DONE;
					end
					default: state_d = idwtd_pkg::S_DONE;
				endcase
			end
			idwtd_pkg::S_SCAN: begin
				if (scan_stat.done) begin
					state_d = idwtd_pkg::S_DONE;
				end
			end
			idwtd_pkg::S_READ: state_d = idwtd_pkg::S_DONE;
			idwtd_pkg::S_DONE: begin
				if (out_free) begin
					state_d = idwtd_pkg::S_IDLE;
				end
			end
			default: state_d = idwtd_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready   = (state_q == idwtd_pkg::S_IDLE);
		scan_start = (state_q == idwtd_pkg::S_EXEC) && (op_q == idwtd_pkg::OP_SUBMIT);
		fifo_rd    = (state_q == idwtd_pkg::S_EXEC) && (op_q == idwtd_pkg::OP_FINISH) &&
			w_ok && !fifo_stat.empty;
		fifo_pop   = (state_q == idwtd_pkg::S_READ);
		fifo_push  = (state_q == idwtd_pkg::S_SCAN) && scan_stat.done && !scan_stat.found &&
			!fifo_stat.full;
		load_out   = (state_q == idwtd_pkg::S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= idwtd_pkg::S_IDLE;
			active_q    <= idwtd_pkg::ACTIVE_RESET;
			poll_mode_q <= 1'b0;
			busy_q      <= '0;
			search_q    <= '0;
			poller_q    <= idwtd_pkg::NO_POLLER;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					idwtd_pkg::CFG_ACTIVE_WORKERS: active_q <= cfg_wdata;
					idwtd_pkg::CFG_POLL_BY_IDLE:   poll_mode_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			case (state_q)
				idwtd_pkg::S_EXEC: begin
					case (op_q)
						idwtd_pkg::OP_FINISH: begin
							// nothing queued: the worker goes idle
							if (w_ok && fifo_stat.empty) begin
								busy_q[wrk_idx] <= 1'b0;
							end
						end
						idwtd_pkg::OP_CLAIM:   poller_q <= idwtd_pkg::POLLER_W'(wrk_q);
						idwtd_pkg::OP_RELEASE: poller_q <= idwtd_pkg::NO_POLLER;
						default: ;
					endcase
				end
				idwtd_pkg::S_SCAN: begin
					if (scan_stat.done) begin
						if (scan_stat.found) begin
							busy_q[scan_idx] <= 1'b1;
							search_q         <= scan_next;
						end else begin
							search_q <= '0;
						end
					end
				end
				idwtd_pkg::S_READ: busy_q[wrk_idx] <= 1'b1;
				default: ;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= idwtd_pkg::op_t'(operation);
			wrk_q <= worker;
			tid_q <= task_id[ID_W-1:0];
			th_q  <= task_handle;
		end
		case (state_q)
			idwtd_pkg::S_EXEC: begin
				res_target_q <= '0;
				res_id_q     <= '0;
				res_th_q     <= '0;
				if (op_q == idwtd_pkg::OP_FINISH && w_ok) begin
					res_status_q <= idwtd_pkg::STS_IDLED;
				end else begin
					res_status_q <= idwtd_pkg::STS_ACK;
				end
			end
			idwtd_pkg::S_SCAN: begin
				if (scan_stat.done) begin
					if (scan_stat.found) begin
						res_status_q <= idwtd_pkg::STS_DISPATCHED;
						res_target_q <= idwtd_pkg::WORKER_W'(scan_idx);
						res_id_q     <= tid_q;
						res_th_q     <= th_q;
					end else begin
						res_status_q <= fifo_stat.full ? idwtd_pkg::STS_DROPPED :
							idwtd_pkg::STS_QUEUED;
					end
				end
			end
			idwtd_pkg::S_READ: begin
				res_status_q <= idwtd_pkg::STS_DISPATCHED;
				res_target_q <= wrk_q;
				res_id_q     <= fifo_rdata[DW-1:HW];
				res_th_q     <= fifo_rdata[HW-1:0];
			end
			default: ;
		endcase
		if (load_out) begin
			out_status_q <= res_status_q;
			out_target_q <= res_target_q;
			out_id_q     <= res_id_q;
			out_th_q     <= res_th_q;
		end
	end

	idwtd_scan #(
		.MAX_WORKERS (MAX_WORKERS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_start),
		.n         (n_w),
		.start_idx (start_idx),
		.busy      (busy_q),
		.poller    (poller_q),
		.poll_mode (poll_mode_q),
		.stat      (scan_stat),
		.idx       (scan_idx),
		.next_idx  (scan_next)
	);

	idwtd_fifo #(
		.DEPTH (QUEUE_DEPTH),
		.DW    (DW)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fifo_push),
		.wdata  ({tid_q, th_q}),
		.rd_req (fifo_rd),
		.pop    (fifo_pop),
		.rdata  (fifo_rdata),
		.stat   (fifo_stat)
	);

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign target_worker   = out_target_q;
	assign out_task_id     = idwtd_pkg::ID_PORT_W'(out_id_q);
	assign out_task_handle = out_th_q;

endmodule

// ===== hdl/idwtd_chk.sv =====
// ---------------------------------------------------------------------------
// idwtd_chk
// Port-level checks on the dispatcher, bound to the top level.
// ---------------------------------------------------------------------------
`include "idle_worker_task_dispatcher_assert.svh"

module idwtd_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [2:0]                      status,
	input logic [idwtd_pkg::WORKER_W-1:0]  target_worker,
	input logic [idwtd_pkg::ID_PORT_W-1:0] out_task_id,
	input logic [idwtd_pkg::HANDLE_W-1:0]  out_task_handle
);

	// hold a stalled result
	`IDWTD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(out_task_id) && $stable(out_task_handle))

	// one item at a time: ready drops after an accepted item
	`IDWTD_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready)

	`IDWTD_ASSERT_IMP(a_status_code, out_valid, status <= idwtd_pkg::STS_ACK)

	// only a dispatch carries a worker and a task
	`IDWTD_ASSERT_IMP(a_zero_payload, out_valid && (status != idwtd_pkg::STS_DISPATCHED), (target_worker == '0) && (out_task_id == '0) && (out_task_handle == '0))

endmodule

bind idle_worker_task_dispatcher idwtd_chk u_idwtd_chk (.*);

// ===== verif/idle_worker_task_dispatcher_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// idle_worker_task_dispatcher_test
// Self-checking bench for the worker dispatcher. Items are sent over the
// input handshake, and a local model of the busy bits, search pointer,
// poller and pending queue predicts each result. A checker compares every
// result with the oldest prediction. Directed cases come first, then a
// queue overflow run and randomised phases over several pool settings.
// ---------------------------------------------------------------------------
module idle_worker_task_dispatcher_test;
	import idwtd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS = 65;

	typedef struct packed {
		status_t             status;
		logic [WORKER_W-1:0] target;
		logic [ID_PORT_W-1:0] id;
		logic [HANDLE_W-1:0]  handle;
	} outcome_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	logic [1:0]            operation;
	logic [WORKER_W-1:0]   worker;
	logic [ID_PORT_W-1:0]  task_id;
	logic [HANDLE_W-1:0]   task_handle;
	logic                  out_valid;
	logic                  out_ready;
	logic [2:0]            status;
	logic [WORKER_W-1:0]   target_worker;
	logic [ID_PORT_W-1:0]  out_task_id;
	logic [HANDLE_W-1:0]   out_task_handle;

	// model of the dispatcher
	logic [ACTIVE_W-1:0]  pool_cfg;
	logic                 poll_cfg;
	bit                   worker_busy [MAX_WORKERS_DEF];
	int                   scan_from;
	logic [POLLER_W-1:0]  poll_owner;
	logic [ID_PORT_W-1:0] backlog_id [QUEUE_DEPTH_DEF];
	logic [HANDLE_W-1:0]  backlog_handle [QUEUE_DEPTH_DEF];
	int                   backlog_head;
	int                   backlog_fill;

	outcome_t awaited_outcomes [$];
	int       errors = 0;
	int       cycles = 0;
	bit       calm = 1'b0;
	int       ready_run = 0;

	idle_worker_task_dispatcher u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.worker          (worker),
		.task_id         (task_id),
		.task_handle     (task_handle),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.target_worker   (target_worker),
		.out_task_id     (out_task_id),
		.out_task_handle (out_task_handle)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic int pool_size();
		if (pool_cfg == 0)
			return 1;
		if (pool_cfg > MAX_WORKERS_DEF)
			return MAX_WORKERS_DEF;
		return int'(pool_cfg);
	endfunction

	function automatic outcome_t dispatch_outcome(input op_t op, input logic [WORKER_W-1:0] w,
			input logic [ID_PORT_W-1:0] tid, input logic [HANDLE_W-1:0] th);
		outcome_t res;
		int n;
		int first;
		int idx;
		int chosen;
		bit poller_skipped;
		int tail;
		res = '{status: STS_ACK, target: '0, id: '0, handle: '0};
		n = pool_size();
		case (op)
			OP_SUBMIT: begin
				first = (scan_from < n) ? scan_from : 0;
				chosen = -1;
				poller_skipped = 1'b0;
				for (int k = 0; k < n; k++) begin
					idx = (first + k) % n;
					if (chosen < 0 && !worker_busy[idx]) begin
						// pass over the poller while another idle worker may exist
						if (poll_cfg && poll_owner == idx)
							poller_skipped = 1'b1;
						else
							chosen = idx;
					end
				end
				if (chosen < 0 && poller_skipped)
					chosen = int'(poll_owner);
				scan_from = (chosen < 0) ? 0 : (chosen + 1) % n;
				if (chosen >= 0) begin
					worker_busy[chosen] = 1'b1;
					res = '{status: STS_DISPATCHED, target: chosen[WORKER_W-1:0], id: tid,
						handle: th};
				end else if (backlog_fill >= QUEUE_DEPTH_DEF) begin
					res.status = STS_DROPPED;
				end else begin
					tail = (backlog_head + backlog_fill) % QUEUE_DEPTH_DEF;
					backlog_id[tail] = tid;
					backlog_handle[tail] = th;
					backlog_fill++;
					res.status = STS_QUEUED;
				end
			end
			OP_FINISH: begin
				if (w < n) begin
					if (backlog_fill > 0) begin
						res = '{status: STS_DISPATCHED, target: w, id: backlog_id[backlog_head],
							handle: backlog_handle[backlog_head]};
						backlog_head = (backlog_head + 1) % QUEUE_DEPTH_DEF;
						backlog_fill--;
						worker_busy[w] = 1'b1;
					end else begin
						worker_busy[w] = 1'b0;
						res.status = STS_IDLED;
					end
				end
			end
			OP_CLAIM:
				poll_owner = {1'b0, w};
			default:
				poll_owner = NO_POLLER;
		endcase
		return res;
	endfunction

	// hold the item until accepted, then record its predicted result
	task automatic send_item(input op_t op, input logic [WORKER_W-1:0] w,
			input logic [ID_PORT_W-1:0] tid, input logic [HANDLE_W-1:0] th);
		operation <= op;
		worker <= w;
		task_id <= tid;
		task_handle <= th;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		awaited_outcomes.push_back(dispatch_outcome(op, w, tid, th));
	endtask

	task automatic drain_outcomes();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// write both registers; only called with nothing in flight
	task automatic set_config(input logic [ACTIVE_W-1:0] active, input logic poll);
		logic [CFG_DATA_W-1:0] poll_word;
		poll_word = {4'($urandom), poll};
		cfg_we <= 1'b1;
		cfg_index <= CFG_ACTIVE_WORKERS;
		cfg_wdata <= active;
		pool_cfg = active;
		@(posedge clk);
		cfg_index <= CFG_POLL_BY_IDLE;
		cfg_wdata <= poll_word;
		poll_cfg = poll_word[0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (awaited_outcomes.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual status %0d worker %0d",
					$time, status, target_worker);
			end else begin
				outcome_t want;
				want = awaited_outcomes.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("target_worker", 32'(want.target), 32'(target_worker));
				check_field("out_task_id", want.id, out_task_id);
				check_field("out_task_handle", want.handle, out_task_handle);
			end
		end
	end

	// receiver: random mix of ready runs and stall bursts
	always @(posedge clk) begin
		if (calm) begin
			out_ready <= 1'b1;
		end else if (ready_run > 0) begin
			ready_run <= ready_run - 1;
		end else if ($urandom_range(0, 2) == 0) begin
			out_ready <= 1'b0;
			ready_run <= $urandom_range(1, 14) - 1;
		end else begin
			out_ready <= 1'b1;
			ready_run <= $urandom_range(1, 20) - 1;
		end
	end

	task automatic test_after_reset();
		send_item(OP_SUBMIT, 4'h0, 32'h0000_0000, 32'hFFFF_FFFF);
		send_item(OP_SUBMIT, 4'hF, 32'hFFFF_FFFF, 32'h0000_0000);
		send_item(OP_FINISH, 4'h1, 32'h0, 32'h0);
		// idle worker finishing with nothing queued stays idle
		send_item(OP_FINISH, 4'hF, 32'h0, 32'h0);
		drain_outcomes();
	endtask

	task automatic test_stale_pointer();
		// pointer sits beyond the shrunk pool, so the search restarts at zero
		set_config(5'd2, 1'b0);
		send_item(OP_SUBMIT, 4'h3, 32'h1234_5678, 32'h9ABC_DEF0);
		send_item(OP_SUBMIT, 4'h0, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
		send_item(OP_FINISH, 4'h0, 32'h0, 32'h0);
		send_item(OP_FINISH, 4'h7, 32'h0, 32'h0);
		send_item(OP_FINISH, 4'h0, 32'h0, 32'h0);
		send_item(OP_FINISH, 4'h1, 32'h0, 32'h0);
		drain_outcomes();
	endtask

	task automatic test_poller_last();
		set_config(5'd4, 1'b1);
		send_item(OP_CLAIM, 4'h0, 32'h0, 32'h0);
		repeat (4)
			send_item(OP_SUBMIT, 4'($urandom), $urandom, $urandom);
		send_item(OP_RELEASE, 4'($urandom), 32'h0, 32'h0);
		send_item(OP_CLAIM, 4'hF, 32'h0, 32'h0);
		drain_outcomes();
	endtask

	task automatic test_queue_full();
		// zero workers counts as one, so the queue fills quickly
		set_config(5'd0, 1'b0);
		while (backlog_fill < QUEUE_DEPTH_DEF)
			send_item(OP_SUBMIT, 4'($urandom), $urandom, $urandom);
		send_item(OP_SUBMIT, 4'($urandom), $urandom, $urandom);
		send_item(OP_FINISH, 4'h0, $urandom, $urandom);
		send_item(OP_FINISH, 4'h1, $urandom, $urandom);
		send_item(OP_RELEASE, 4'($urandom), $urandom, $urandom);
		drain_outcomes();
	endtask

	task automatic test_random_mix();
		logic [ACTIVE_W-1:0] pool_choice [RANDOM_PHASES];
		op_t op;
		logic [WORKER_W-1:0] w;
		int roll;
		int n;
		int busy_pick [$];
		pool_choice = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd3, 5'd17, 5'($urandom_range(1, 31)), 5'd2,
			5'($urandom_range(4, 15)), 5'd16};
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph == RANDOM_PHASES - 1)
				calm = 1'b1;
			set_config(pool_choice[ph], (ph == 6) ? 1'($urandom) : ph[0]);
			for (int it = 0; it < PHASE_ITEMS; it++) begin
				n = pool_size();
				roll = $urandom_range(0, 99);
				if (roll < 45)
					op = OP_SUBMIT;
				else if (roll < 80)
					op = OP_FINISH;
				else if (roll < 90)
					op = OP_CLAIM;
				else
					op = OP_RELEASE;
				w = 4'($urandom);
				if (op == OP_FINISH && $urandom_range(0, 3) != 0) begin
					busy_pick.delete();
					for (int i = 0; i < n; i++)
						if (worker_busy[i])
							busy_pick.push_back(i);
					if (busy_pick.size() != 0)
						w = 4'(busy_pick[$urandom_range(0, busy_pick.size() - 1)]);
				end else if (op == OP_CLAIM && $urandom_range(0, 3) != 0) begin
					w = 4'($urandom_range(0, n - 1));
				end
				if (!calm && $urandom_range(0, 3) == 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 14))
						@(posedge clk);
				end
				send_item(op, w, $urandom, $urandom);
				// hold off mid-phase until every result is back
				if (ph == 4 && it == PHASE_ITEMS / 2)
					drain_outcomes();
			end
			drain_outcomes();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		operation = '0;
		worker = '0;
		task_id = '0;
		task_handle = '0;
		out_ready = 1'b0;
		pool_cfg = ACTIVE_RESET;
		poll_cfg = 1'b0;
		foreach (worker_busy[i])
			worker_busy[i] = 1'b0;
		scan_from = 0;
		poll_owner = NO_POLLER;
		backlog_head = 0;
		backlog_fill = 0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_stale_pointer();
		test_poller_last();
		test_queue_full();
		test_random_mix();

		drain_outcomes();
		repeat (40)
			@(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
